// File: src/assert_macros.svh
// assertion macros shared by the halftoner rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, sampled on the rising clock, off in reset
`define SEDH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// condition that must never be seen outside reset
`define SEDH_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: src/sedh_pkg.sv
// shared constants and types of the serpentine error diffusion halftoner
// no dependencies; used by sedh_err_ram and the top level
package sedh_pkg;

    // default sizes of the design
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_CHANNELS      = 3;
    localparam int DEF_FRACTION_BITS = 8;
    // integer bits of an error word above the fraction
    localparam int ERR_INT_BITS      = 10;
    localparam int DEF_MEM_W         = DEF_CHANNELS * (DEF_FRACTION_BITS + ERR_INT_BITS);

    // frame height limit and row counter width
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;

    // stream and configuration widths
    localparam int SAMPLE_W   = 8;
    localparam int RGB_W      = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    // register reset values
    localparam logic [SAMPLE_W-1:0]   THRESHOLD_RESET = 8'd100;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET     = 11'd600;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET    = 11'd400;

    // full ink level and diffusion weights over sixteen
    localparam logic [SAMPLE_W-1:0] FULL_INK = 8'd255;
    localparam int WEIGHT_W = 3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FORWARD = 3'd7;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BEHIND  = 3'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BELOW   = 3'd5;
    localparam logic [WEIGHT_W-1:0] WEIGHT_AHEAD   = 3'd1;
    localparam int SHARE_SHIFT = 4;
    localparam int SHARE_BIAS  = (1 << SHARE_SHIFT) - 1;

endpackage

// File: src/sedh_err_ram.sv
// row error memory: one write port, two registered read ports, clearing pass after reset
// depends on sedh_pkg for default sizes
module sedh_err_ram #(
    parameter int DEPTH  = sedh_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = sedh_pkg::DEF_MEM_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_a,
    output logic [DATA_W-1:0]        o_rdata_b,
    output logic                     o_clearing
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // clearing pass, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // write port and registered reads, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a  = r_rdata_a;
    assign o_rdata_b  = r_rdata_b;
    assign o_clearing = r_clearing;

endmodule

// File: src/serpentine_error_diffusion_halftone_top.sv
// top level of the serpentine floyd-steinberg halftoner
// depends on sedh_pkg, sedh_err_ram and assert_macros.svh
//
// usage:
//   slave stream: one rgb pixel per transaction, pixels in serpentine order
//     (even rows left to right, odd rows right to left)
//   master stream: one transaction per pixel with the three rgb on bits in
//     tdata, tlast on the last pixel of a row, tuser on the last of a frame
//   config port: threshold, width and height, written while the block is idle
// throughput: one pixel per clock while the receiver keeps tready high; the
//   forward error loop closes within the compute stage and the row memory is
//   read and written once per pixel on its own ports
// path: the row memory read and the compute stage are loaded together when a
//   pixel is accepted, then the result is computed into the output register
// reset: control and configuration registers return to their defaults; after
//   reset the row memory is cleared one column a cycle, with tready low
// stall: while the output register waits, one more pixel is taken into the
//   compute stage; then tready drops until the receiver takes the result
`include "assert_macros.svh"

module serpentine_error_diffusion_halftone_top #(
    parameter int MAX_WIDTH     = sedh_pkg::DEF_MAX_WIDTH,
    parameter int CHANNELS      = sedh_pkg::DEF_CHANNELS,
    parameter int FRACTION_BITS = sedh_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel in: red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sedh_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // result out: red_on [0], green_on [1], blue_on [2], zero fill above
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [sedh_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // frame_end [0]
    output logic                              o_m_axis_tuser,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [sedh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sedh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = sedh_pkg::ROW_W;
    localparam int EB     = FRACTION_BITS + sedh_pkg::ERR_INT_BITS;
    localparam int WIDE   = EB + 5;
    localparam int MEM_W  = CHANNELS * EB;
    localparam int SMP_W  = sedh_pkg::SAMPLE_W;
    localparam int VPAD   = EB + 2 - SMP_W - FRACTION_BITS;
    localparam int RGB_W  = sedh_pkg::RGB_W;
    localparam int CFG_W  = sedh_pkg::CFG_DATA_W;
    localparam logic signed [WIDE-1:0] SAT_HI = WIDE'((1 << (EB - 1)) - 1);
    localparam logic signed [WIDE-1:0] SAT_LO = WIDE'(-(1 << (EB - 1)));

    // last column index from a raw width value
    function automatic logic [COL_W-1:0] f_col_last(input logic [CFG_W-1:0] v);
        int iv;
        iv = int'(v);
        if (iv == 0) iv = 1;
        if (iv > MAX_WIDTH) iv = MAX_WIDTH;
        return COL_W'(iv - 1);
    endfunction

    // last row index from a raw height value
    function automatic logic [ROW_W-1:0] f_row_last(input logic [CFG_W-1:0] v);
        int iv;
        iv = int'(v);
        if (iv == 0) iv = 1;
        if (iv > sedh_pkg::MAX_HEIGHT) iv = sedh_pkg::MAX_HEIGHT;
        return ROW_W'(iv - 1);
    endfunction

    // clamp to the error word range
    function automatic logic signed [EB-1:0] f_sat(input logic signed [WIDE-1:0] v);
        if (v > SAT_HI) return EB'(SAT_HI);
        if (v < SAT_LO) return EB'(SAT_LO);
        return EB'(v);
    endfunction

    // weighted share e*w/16, truncated toward zero
    function automatic logic signed [EB-1:0] f_share(
        input logic signed [EB-1:0]                 e,
        input logic [sedh_pkg::WEIGHT_W-1:0]        w
    );
        logic signed [EB+3:0] prod;
        logic signed [EB+3:0] q;
        prod = (EB+4)'(e) * $signed({{(EB+4-sedh_pkg::WEIGHT_W){1'b0}}, w});
        if (prod < 0) prod = prod + (EB+4)'(sedh_pkg::SHARE_BIAS);
        q = prod >>> sedh_pkg::SHARE_SHIFT;
        return q[EB-1:0];
    endfunction

    // configuration registers, sizes kept as clamped last indexes
    logic [SMP_W-1:0] r_thr;
    logic [COL_W-1:0] r_col_last;
    logic [ROW_W-1:0] r_row_last;

    // scan position
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // compute stage
    logic             r_b_valid;
    logic [COL_W-1:0] r_b_x;
    logic [COL_W-1:0] r_b_xb;
    logic             r_b_behind;
    logic             r_b_top;
    logic             r_b_last_col;
    logic             r_b_frame_end;
    logic             r_b_byp_a;
    logic             r_b_byp_b;
    logic [MEM_W-1:0] r_b_byp_d;

    // column of the previous pixel whose below value is still held here
    logic             r_pend_valid;
    logic [COL_W-1:0] r_pend_x;

    // output register
    logic             r_o_valid;
    logic [RGB_W-1:0] r_o_rgb;
    logic             r_o_last;
    logic             r_o_user;

    logic             accept;
    logic             b_adv;
    logic             ram_clearing;
    logic [MEM_W-1:0] ram_rd_a;
    logic [MEM_W-1:0] ram_rd_b;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [MEM_W-1:0] wr_data;
    logic [COL_W-1:0] pos_p;
    logic [ROW_W-1:0] pos_r;
    logic [COL_W-1:0] pos_x;
    logic [COL_W-1:0] pos_xb;
    logic             pos_last_col;
    logic             pos_last_row;
    logic [RGB_W-1:0] rgb;
    wire  [MEM_W-1:0] pend_pk;
    wire  [MEM_W-1:0] xb_new_pk;
    wire  [CHANNELS-1:0] ink_w;

    // handshakes
    assign b_adv           = r_b_valid & (~r_o_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~ram_clearing & (~r_b_valid | b_adv);
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= sedh_pkg::THRESHOLD_RESET;
            r_col_last <= f_col_last(sedh_pkg::WIDTH_RESET);
            r_row_last <= f_row_last(sedh_pkg::HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (sedh_pkg::t_cfg_idx'(i_cfg_index))
                sedh_pkg::CFG_THRESHOLD: r_thr      <= i_cfg_data[SMP_W-1:0];
                sedh_pkg::CFG_WIDTH:     r_col_last <= f_col_last(i_cfg_data);
                sedh_pkg::CFG_HEIGHT:    r_row_last <= f_row_last(i_cfg_data);
                default: ;
            endcase
        end
    end

    // position of the incoming pixel, clamped to the current size
    always_comb begin
        pos_p        = (r_col > r_col_last) ? r_col_last : r_col;
        pos_r        = (r_row > r_row_last) ? r_row_last : r_row;
        pos_x        = pos_r[0] ? (r_col_last - pos_p) : pos_p;
        pos_xb       = pos_r[0] ? (pos_x + COL_W'(1)) : (pos_x - COL_W'(1));
        pos_last_col = (pos_p == r_col_last);
        pos_last_row = (pos_r == r_row_last);
    end

    // scan position advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (pos_last_col) begin
                r_col <= '0;
                r_row <= pos_last_row ? '0 : (pos_r + ROW_W'(1));
            end else begin
                r_col <= pos_p + COL_W'(1);
                r_row <= pos_r;
            end
        end
    end

    // compute stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    // compute stage payload, with capture of a write landing on the read edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_x         <= pos_x;
            r_b_xb        <= pos_xb;
            r_b_behind    <= (pos_p != '0);
            r_b_top       <= (pos_r == '0);
            r_b_last_col  <= pos_last_col;
            r_b_frame_end <= pos_last_col & pos_last_row;
            r_b_byp_a     <= wr_en & (wr_addr == pos_x);
            r_b_byp_b     <= wr_en & (wr_addr == pos_xb);
            r_b_byp_d     <= wr_data;
        end
    end

    // per-channel quantiser and error shares
    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        logic [SMP_W-1:0]     sample;
        logic [SMP_W-1:0]     r_b_cmy;
        logic signed [EB-1:0] r_fwd;
        logic signed [EB-1:0] r_diag;
        logic signed [EB-1:0] r_pend;
        logic signed [EB-1:0] below;
        logic signed [EB-1:0] base_b;
        logic signed [EB-1:0] acc;
        logic signed [EB-1:0] e;
        logic signed [EB-1:0] s7;
        logic signed [EB-1:0] s5;
        logic signed [EB-1:0] s3;
        logic signed [EB-1:0] s1;
        logic signed [EB-1:0] n_pend;
        logic signed [EB-1:0] n_xb;
        logic signed [EB+1:0] v;
        logic signed [EB+1:0] e_full;
        logic signed [EB+1:0] thr_s;
        logic signed [EB+1:0] full_s;
        logic                 ink;

        if (c < RGB_W) begin : g_smp
            assign sample = i_s_axis_tdata[c*SMP_W +: SMP_W];
        end else begin : g_nosmp
            assign sample = '0;
        end

        // cmy value of the incoming sample
        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_b_cmy <= ~sample;
            end
        end

        // below value: zero on the top row, else held column first, then a same-edge write, then memory
        always_comb begin
            if (r_b_top) begin
                below = '0;
            end else if (r_pend_valid && (r_pend_x == r_b_x)) begin
                below = r_pend;
            end else if (r_b_byp_a) begin
                below = r_b_byp_d[c*EB +: EB];
            end else begin
                below = ram_rd_a[c*EB +: EB];
            end

            if (r_pend_valid && (r_pend_x == r_b_xb)) begin
                base_b = r_pend;
            end else if (r_b_byp_b) begin
                base_b = r_b_byp_d[c*EB +: EB];
            end else begin
                base_b = ram_rd_b[c*EB +: EB];
            end

            thr_s  = $signed({{VPAD{1'b0}}, r_thr, {FRACTION_BITS{1'b0}}});
            full_s = $signed({{VPAD{1'b0}}, sedh_pkg::FULL_INK, {FRACTION_BITS{1'b0}}});
            acc    = f_sat(WIDE'(below) + WIDE'(r_fwd));
            v      = $signed({{VPAD{1'b0}}, r_b_cmy, {FRACTION_BITS{1'b0}}}) + (EB+2)'(acc);
            ink    = (v >= thr_s);
            e_full = ink ? (v - full_s) : v;
            e      = e_full[EB-1:0];

            s7     = f_share(e, sedh_pkg::WEIGHT_FORWARD);
            s5     = f_share(e, sedh_pkg::WEIGHT_BELOW);
            s3     = f_share(e, sedh_pkg::WEIGHT_BEHIND);
            s1     = f_share(e, sedh_pkg::WEIGHT_AHEAD);
            n_pend = f_sat(WIDE'(r_diag) + WIDE'(s5));
            n_xb   = f_sat(WIDE'(base_b) + WIDE'(s3));
        end

        // forward and diagonal errors, dropped at the row end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fwd  <= '0;
                r_diag <= '0;
            end else if (b_adv) begin
                r_fwd  <= r_b_last_col ? '0 : s7;
                r_diag <= r_b_last_col ? '0 : s1;
            end
        end

        // below value of this pixel, written back by the next one
        always_ff @(posedge i_clk) begin
            if (b_adv) begin
                r_pend <= n_pend;
            end
        end

        assign pend_pk[c*EB +: EB]   = r_pend;
        assign xb_new_pk[c*EB +: EB] = n_xb;
        assign ink_w[c]              = ink;
    end

    // held column tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (b_adv) begin
            r_pend_valid <= 1'b1;
        end else if (i_cfg_we) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_pend_x <= r_b_x;
        end
    end

    // memory write: behind share merged into the held column, else flush it, also on a configuration write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_x;
        wr_data = pend_pk;
        if (b_adv) begin
            if (r_b_behind) begin
                wr_en   = 1'b1;
                wr_addr = r_b_xb;
                wr_data = xb_new_pk;
            end else if (r_pend_valid) begin
                wr_en = 1'b1;
            end
        end else if (i_cfg_we && r_pend_valid) begin
            wr_en = 1'b1;
        end
    end

    sedh_err_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (MEM_W)
    ) u_err_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (wr_en),
        .i_waddr    (wr_addr),
        .i_wdata    (wr_data),
        .i_re       (accept),
        .i_raddr_a  (pos_x),
        .i_raddr_b  (pos_xb),
        .o_rdata_a  (ram_rd_a),
        .o_rdata_b  (ram_rd_b),
        .o_clearing (ram_clearing)
    );

    // ink bits back to rgb, absent channels read zero
    for (genvar i = 0; i < RGB_W; i++) begin : g_rgb
        if (i < CHANNELS) begin : g_on
            assign rgb[i] = ~ink_w[i];
        end else begin : g_off
            assign rgb[i] = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_o_rgb  <= rgb;
            r_o_last <= r_b_last_col;
            r_o_user <= r_b_frame_end;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(sedh_pkg::M_TDATA_W-RGB_W){1'b0}}, r_o_rgb};
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_user;

    // checks
    `SEDH_ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n, accept && ram_clearing, "pixel taken during memory clear")
    `SEDH_ASSERT(a_frame_end_ends_row, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast, "frame end without row end")
    `SEDH_ASSERT(a_pend_after_pixel, i_clk, i_rst_n, b_adv |=> r_pend_valid, "held column lost after a pixel")
    `SEDH_ASSERT(a_behind_hits_pend, i_clk, i_rst_n, (b_adv && r_b_behind && r_pend_valid) |-> (r_pend_x == r_b_xb), "behind share misses held column")

endmodule
